/* hw/rtl/heightfield_water_flow_step_defines.svh */
// Assertion helpers for the heightfield water flow block.
`ifndef HEIGHTFIELD_WATER_FLOW_STEP_DEFINES_SVH
`define HEIGHTFIELD_WATER_FLOW_STEP_DEFINES_SVH

`ifndef SYNTHESIS
`define HWFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define HWFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HWFS_ASSERT(lbl, prop, msg)
`define HWFS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/hwfs_pkg.sv */
package hwfs_pkg;

  localparam int GridSideDefault = 129;

  localparam int CMD_W    = 2;
  localparam int CIDX_W   = 15;
  localparam int GROUND_W = 8;
  localparam int WATER_W  = 28;
  localparam int SURF_W   = 29;
  localparam int STAT_W   = 2;
  localparam int THR_W    = 16;
  localparam int SUM_W    = 32;
  localparam int PROD_W   = WATER_W + SURF_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int DCNT_W   = $clog2(DIV_STEPS + 1);
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [THR_W-1:0]   THR_RESET = THR_W'(66);
  localparam logic [WATER_W-1:0] WATER_MAX = 28'hFFF_FFFF;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_STEP  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  localparam logic [PADDR_W-1:0] REG_THRESHOLD = 3'd0;

  // neighbour order: row -1, 0, +1; column -1, 0, +1; center skipped
  function automatic logic nb_up(input logic [2:0] k);
    return (k <= 3'd2);
  endfunction

  function automatic logic nb_down(input logic [2:0] k);
    return (k >= 3'd5);
  endfunction

  function automatic logic nb_left(input logic [2:0] k);
    return (k == 3'd0) || (k == 3'd3) || (k == 3'd5);
  endfunction

  function automatic logic nb_right(input logic [2:0] k);
    return (k == 3'd2) || (k == 3'd4) || (k == 3'd7);
  endfunction

endpackage

/* hw/rtl/heightfield_water_flow_step.sv */
// channel  dir  handshake                 word
// in       in   in_valid_i / in_ready_o   command, cell_index, ground_height, water_level
// out      out  out_valid_o / out_ready_i water_out, surface_out, status
// cfg      in   APB psel/penable/pready   flow_threshold at byte 0
//
// Load and out-of-grid words are answered straight from idle; in-grid reads take one memory read (S_RD).
// A step copies water into the snapshot, then walks the cells in order: a dry cell
// is passed over, a wet one scans its eight neighbours and divides for dw when one is lower,
// then divides once more per lower neighbour (shared 57-step divider) when water moves.
// Input is held off for the whole step. Memories are not cleared by reset.
`include "heightfield_water_flow_step_defines.svh"

module heightfield_water_flow_step
  import hwfs_pkg::*;
#(
  parameter int GRID_SIDE = GridSideDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [CIDX_W-1:0]   cell_index_i,
  input  logic [GROUND_W-1:0] ground_height_i,
  input  logic [WATER_W-1:0]  water_level_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [WATER_W-1:0]  water_out_o,
  output logic [SURF_W-1:0]   surface_out_o,
  output logic [STAT_W-1:0]   status_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int IDX_W = $clog2(CELLS);
  localparam int RC_W  = $clog2(GRID_SIDE);

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_COPY, S_CELL, S_CELLW, S_NB, S_CHK, S_DIV, S_GATE,
    S_SHARE, S_MUL, S_ADDRD, S_ADDWR, S_SELFRD, S_SELFWR, S_NEXT, S_DONE
  } state_e;

  state_e st_q;

  logic [THR_W-1:0] thr_q;

  // memories
  logic [GROUND_W-1:0] ter_mem [0:CELLS-1];
  logic [WATER_W-1:0]  wat_mem [0:CELLS-1];
  logic [WATER_W-1:0]  snp_mem [0:CELLS-1];
  logic [GROUND_W-1:0] ter_rd_q;
  logic [WATER_W-1:0]  wat_rd_q, snp_rd_q;
  logic [IDX_W-1:0]    ter_ra, wat_ra, snp_ra, wat_wa;
  logic                wat_we;
  logic [WATER_W-1:0]  wat_wd;

  // output register
  logic                out_valid_q;
  logic [WATER_W-1:0]  water_out_q;
  logic [SURF_W-1:0]   surface_out_q;
  logic [STAT_W-1:0]   status_q;

  // sweep and cell state
  logic [IDX_W:0]      cp_q;
  logic [IDX_W-1:0]    cpa_q;
  logic                cpv_q;
  logic [IDX_W-1:0]    cell_q;
  logic [RC_W-1:0]     row_q, col_q;
  logic [WATER_W-1:0]  w_q, dw_q;
  logic [SURF_W-1:0]   h_q;
  logic [SUM_W-1:0]    sum_q;
  logic [3:0]          n_q, k_q;
  logic                pv_q, pin_q;
  logic [2:0]          pk_q;
  logic [SURF_W-1:0]   drop_q [8];

  // shared divider
  logic [PROD_W-1:0]   dq_q;
  logic [SUM_W-1:0]    rem_q, div_d_q;
  logic [DCNT_W-1:0]   dcnt_q;
  logic                dret_q;

  logic                in_acc, in_range;
  logic [IDX_W-1:0]    in_addr;
  logic [IDX_W-1:0]    nb_addr;
  logic                nb_in;
  logic [SURF_W-1:0]   nh, drop_sel;
  logic [SUM_W:0]      dv_t;
  logic                dv_ge;
  logic [SUM_W-1:0]    dv_rem;
  logic [PROD_W-1:0]   prod;
  logic [SURF_W-1:0]   add_v;

  assign in_ready_o = (st_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_range   = 32'(cell_index_i) < 32'(CELLS);
  assign in_addr    = IDX_W'(cell_index_i);

  assign out_valid_o   = out_valid_q;
  assign water_out_o   = water_out_q;
  assign surface_out_o = surface_out_q;
  assign status_o      = status_q;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_THRESHOLD[PADDR_W-1:2]) ?
                  PDATA_W'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1:2] == REG_THRESHOLD[PADDR_W-1:2]) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  // neighbour address of k_q around the current cell
  always_comb begin
    logic [2:0] k;
    k = k_q[2:0];
    nb_in = !((nb_up(k) && row_q == '0) ||
              (nb_down(k) && row_q == RC_W'(GRID_SIDE - 1)) ||
              (nb_left(k) && col_q == '0) ||
              (nb_right(k) && col_q == RC_W'(GRID_SIDE - 1)));
    nb_addr = cell_q;
    if (nb_up(k)) begin
      nb_addr = nb_addr - IDX_W'(GRID_SIDE);
    end else if (nb_down(k)) begin
      nb_addr = nb_addr + IDX_W'(GRID_SIDE);
    end
    if (nb_left(k)) begin
      nb_addr = nb_addr - IDX_W'(1);
    end else if (nb_right(k)) begin
      nb_addr = nb_addr + IDX_W'(1);
    end
  end

  // read address selection
  always_comb begin
    ter_ra = in_addr;
    snp_ra = cell_q;
    wat_ra = in_addr;
    unique case (st_q)
      S_COPY:                  wat_ra = cp_q[IDX_W-1:0];
      S_CELL: begin
        ter_ra = cell_q;
        snp_ra = cell_q;
      end
      S_NB: begin
        ter_ra = nb_addr;
        snp_ra = nb_addr;
      end
      S_ADDRD, S_ADDWR:        wat_ra = nb_addr;
      S_SELFRD, S_SELFWR:      wat_ra = cell_q;
      default: ;
    endcase
  end

  assign add_v = SURF_W'(wat_rd_q) + SURF_W'(dq_q[WATER_W-1:0]);

  // water write port
  always_comb begin
    wat_we = 1'b0;
    wat_wa = in_addr;
    wat_wd = water_level_i;
    unique case (st_q)
      S_IDLE: wat_we = in_acc && command_i == CMD_LOAD && in_range;
      S_ADDWR: begin
        wat_we = 1'b1;
        wat_wa = nb_addr;
        wat_wd = (add_v > SURF_W'(WATER_MAX)) ? WATER_MAX : add_v[WATER_W-1:0];
      end
      S_SELFWR: begin
        wat_we = 1'b1;
        wat_wa = cell_q;
        wat_wd = (wat_rd_q >= dw_q) ? (wat_rd_q - dw_q) : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wat_we) begin
      wat_mem[wat_wa] <= wat_wd;
    end
    wat_rd_q <= wat_mem[wat_ra];
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && in_acc && command_i == CMD_LOAD && in_range) begin
      ter_mem[in_addr] <= ground_height_i;
    end
    ter_rd_q <= ter_mem[ter_ra];
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_COPY && cpv_q) begin
      snp_mem[cpa_q] <= wat_rd_q;
    end
    snp_rd_q <= snp_mem[snp_ra];
  end

  assign nh       = SURF_W'({ter_rd_q, 16'h0000}) + SURF_W'(snp_rd_q);
  assign drop_sel = drop_q[k_q[2:0]];
  assign prod     = dw_q * drop_sel;

  // one restoring step: shift in the next dividend bit
  assign dv_t   = {rem_q, dq_q[PROD_W-1]};
  assign dv_ge  = dv_t >= {1'b0, div_d_q};
  assign dv_rem = dv_ge ? SUM_W'(dv_t - {1'b0, div_d_q}) : dv_t[SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= S_IDLE;
      out_valid_q   <= 1'b0;
      water_out_q   <= '0;
      surface_out_q <= '0;
      status_q      <= STAT_DONE;
      cp_q          <= '0;
      cpa_q         <= '0;
      cpv_q         <= 1'b0;
      cell_q        <= '0;
      row_q         <= '0;
      col_q         <= '0;
      w_q           <= '0;
      dw_q          <= '0;
      h_q           <= '0;
      sum_q         <= '0;
      n_q           <= '0;
      k_q           <= '0;
      pv_q          <= 1'b0;
      pin_q         <= 1'b0;
      pk_q          <= '0;
      drop_q        <= '{default: '0};
      dq_q          <= '0;
      rem_q         <= '0;
      div_d_q       <= '0;
      dcnt_q        <= '0;
      dret_q        <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (in_acc) begin
            water_out_q   <= '0;
            surface_out_q <= '0;
            unique case (command_i)
              CMD_LOAD: begin
                out_valid_q <= 1'b1;
                status_q    <= in_range ? STAT_DONE : STAT_RANGE;
              end
              CMD_STEP: begin
                cp_q  <= '0;
                cpv_q <= 1'b0;
                st_q  <= S_COPY;
              end
              CMD_READ: begin
                if (in_range) begin
                  st_q <= S_RD;
                end else begin
                  out_valid_q <= 1'b1;
                  status_q    <= STAT_RANGE;
                end
              end
              CMD_NOP: begin
                out_valid_q <= 1'b1;
                status_q    <= STAT_DONE;
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          out_valid_q   <= 1'b1;
          status_q      <= STAT_DONE;
          water_out_q   <= wat_rd_q;
          surface_out_q <= SURF_W'({ter_rd_q, 16'h0000}) + SURF_W'(wat_rd_q);
          st_q          <= S_IDLE;
        end
        S_COPY: begin
          cpa_q <= cp_q[IDX_W-1:0];
          cpv_q <= cp_q < (IDX_W+1)'(CELLS);
          if (cp_q < (IDX_W+1)'(CELLS)) begin
            cp_q <= cp_q + 1'b1;
          end else begin
            cell_q <= '0;
            row_q  <= '0;
            col_q  <= '0;
            st_q   <= S_CELL;
          end
        end
        S_CELL: st_q <= S_CELLW;
        S_CELLW: begin
          w_q   <= snp_rd_q;
          h_q   <= SURF_W'({ter_rd_q, 16'h0000}) + SURF_W'(snp_rd_q);
          sum_q <= '0;
          n_q   <= '0;
          k_q   <= '0;
          pv_q  <= 1'b0;
          st_q  <= (snp_rd_q == '0) ? S_NEXT : S_NB;
        end
        S_NB: begin
          // reads issue for k_q, results of the previous k land now
          if (pv_q) begin
            if (pin_q && h_q > nh) begin
              drop_q[pk_q] <= h_q - nh;
              sum_q        <= sum_q + SUM_W'(h_q - nh);
              n_q          <= n_q + 1'b1;
            end else begin
              drop_q[pk_q] <= '0;
            end
          end
          pv_q  <= k_q < 4'd8;
          pin_q <= nb_in;
          pk_q  <= k_q[2:0];
          if (k_q == 4'd8) begin
            st_q <= S_CHK;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_CHK: begin
          if (n_q == '0 || sum_q == '0) begin
            st_q <= S_NEXT;
          end else begin
            dq_q    <= (SUM_W'(w_q) < sum_q) ? PROD_W'(w_q) : PROD_W'(sum_q);
            rem_q   <= '0;
            div_d_q <= SUM_W'(n_q) + SUM_W'(1);
            dcnt_q  <= '0;
            dret_q  <= 1'b0;
            st_q    <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q  <= dv_rem;
          dq_q   <= {dq_q[PROD_W-2:0], dv_ge};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) begin
            st_q <= dret_q ? S_ADDRD : S_GATE;
          end
        end
        S_GATE: begin
          dw_q <= dq_q[WATER_W-1:0];
          k_q  <= '0;
          st_q <= (dq_q[WATER_W-1:0] > WATER_W'(thr_q)) ? S_SHARE : S_NEXT;
        end
        S_SHARE: begin
          if (k_q == 4'd8) begin
            st_q <= S_SELFRD;
          end else if (drop_sel != '0) begin
            st_q <= S_MUL;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_MUL: begin
          dq_q    <= prod;
          rem_q   <= '0;
          div_d_q <= sum_q;
          dcnt_q  <= '0;
          dret_q  <= 1'b1;
          st_q    <= S_DIV;
        end
        S_ADDRD: st_q <= S_ADDWR;
        S_ADDWR: begin
          k_q  <= k_q + 1'b1;
          st_q <= S_SHARE;
        end
        S_SELFRD: st_q <= S_SELFWR;
        S_SELFWR: st_q <= S_NEXT;
        S_NEXT: begin
          if (cell_q == IDX_W'(CELLS - 1)) begin
            st_q <= S_DONE;
          end else begin
            cell_q <= cell_q + 1'b1;
            st_q   <= S_CELL;
            if (col_q == RC_W'(GRID_SIDE - 1)) begin
              col_q <= '0;
              row_q <= row_q + 1'b1;
            end else begin
              col_q <= col_q + 1'b1;
            end
          end
        end
        S_DONE: begin
          out_valid_q   <= 1'b1;
          status_q      <= STAT_STEP;
          water_out_q   <= '0;
          surface_out_q <= '0;
          st_q          <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  `HWFS_ASSERT(a_rd_slot_free, st_q != S_RD || !out_valid_q, "read result would overwrite word")
  `HWFS_ASSERT_NEXT(a_step_no_word, in_acc && command_i == CMD_STEP, !out_valid_q, "step answered early")
  `HWFS_ASSERT(a_k_range, k_q <= 4'd8, "neighbour counter out of range")
  `HWFS_ASSERT(a_div_range, dcnt_q <= DCNT_W'(DIV_STEPS), "divider count overrun")
  `HWFS_ASSERT(a_lower_count, st_q != S_CHK || n_q <= 4'd8, "too many lower neighbours")

endmodule

/* bench/testbench.sv */
module testbench;
  import hwfs_pkg::*;

  localparam int Side = GridSideDefault;
  localparam int Cells = Side * Side;
  localparam int StallLimit = 30_000_000;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [CIDX_W-1:0]   idx;
    logic [GROUND_W-1:0] ground;
    logic [WATER_W-1:0]  water;
  } cell_word_t;

  typedef struct packed {
    logic [WATER_W-1:0] water;
    logic [SURF_W-1:0]  surface;
    logic [STAT_W-1:0]  status;
  } answer_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [CMD_W-1:0]    command_i = '0;
  logic [CIDX_W-1:0]   cell_index_i = '0;
  logic [GROUND_W-1:0] ground_height_i = '0;
  logic [WATER_W-1:0]  water_level_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [WATER_W-1:0]  water_out_o;
  logic [SURF_W-1:0]   surface_out_o;
  logic [STAT_W-1:0]   status_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  heightfield_water_flow_step dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // model of the grid
  logic [GROUND_W-1:0] terrain_m [Cells];
  logic [WATER_W-1:0]  water_m [Cells];
  logic [WATER_W-1:0]  snap_m [Cells];
  logic [THR_W-1:0]    threshold_m = THR_RESET;

  cell_word_t pending_q[$];
  answer_t    answers_q[$];
  int         errors = 0;
  int         idle_cycles = 0;
  int         in_gap = 0;
  int         out_stall = 0;
  bit         in_taken = 1'b0;
  bit         bursty = 1'b0;

  function automatic longint surf_of(int i);
    return (longint'(terrain_m[i]) << 16) + longint'(snap_m[i]);
  endfunction

  function automatic void add_water(int i, longint amount);
    longint v;
    v = longint'(water_m[i]) + amount;
    water_m[i] = (v > longint'(WATER_MAX)) ? WATER_MAX : v[WATER_W-1:0];
  endfunction

  function automatic void flow_cell(int r, int c);
    int self, n, k, nr, nc, j;
    longint h, nh, sum, m, dw;
    longint drop [8];
    int nidx [8];
    self = r * Side + c;
    sum = 0;
    n = 0;
    k = 0;
    if (snap_m[self] == 0) return;
    h = surf_of(self);
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr == 0 && dc == 0) continue;
        nr = r + dr;
        nc = c + dc;
        drop[k] = 0;
        nidx[k] = 0;
        if (nr >= 0 && nr < Side && nc >= 0 && nc < Side) begin
          j = nr * Side + nc;
          nh = surf_of(j);
          nidx[k] = j;
          if (h > nh) begin
            drop[k] = h - nh;
            sum += drop[k];
            n++;
          end
        end
        k++;
      end
    end
    if (n == 0 || sum == 0) return;
    m = (longint'(snap_m[self]) < sum) ? longint'(snap_m[self]) : sum;
    dw = m / (n + 1);
    if (dw <= longint'(threshold_m)) return;
    for (k = 0; k < 8; k++)
      if (drop[k] != 0) add_water(nidx[k], (dw * drop[k]) / sum);
    if (longint'(water_m[self]) >= dw) water_m[self] = water_m[self] - dw[WATER_W-1:0];
    else water_m[self] = '0;
  endfunction

  function automatic answer_t apply_word(cell_word_t w);
    answer_t a;
    a = '0;
    a.status = STAT_DONE;
    if (w.cmd == CMD_LOAD || w.cmd == CMD_READ) begin
      if (int'(w.idx) >= Cells) begin
        a.status = STAT_RANGE;
      end else if (w.cmd == CMD_LOAD) begin
        terrain_m[w.idx] = w.ground;
        water_m[w.idx] = w.water;
      end else begin
        a.water = water_m[w.idx];
        a.surface = SURF_W'({terrain_m[w.idx], 16'h0}) + SURF_W'(water_m[w.idx]);
      end
    end else if (w.cmd == CMD_STEP) begin
      snap_m = water_m;
      for (int r = 0; r < Side; r++)
        for (int c = 0; c < Side; c++)
          flow_cell(r, c);
      a.status = STAT_STEP;
    end
    return a;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // word driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cell_word_t w;
          w = pending_q.pop_front();
          command_i <= w.cmd;
          cell_index_i <= w.idx;
          ground_height_i <= w.ground;
          water_level_i <= w.water;
          in_valid_i <= 1'b1;
          if ($urandom_range(0, 63) == 0) bursty = !bursty;
          in_gap = bursty ? 0 : $urandom_range(0, 4);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    in_taken = 1'b0;
    idle_cycles++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      answer_t a;
      idle_cycles = 0;
      if (answers_q.size() == 0) begin
        report("unexpected word", 32'(status_o), 32'(0));
      end else begin
        a = answers_q.pop_front();
        if (water_out_o !== a.water)
          report("water_out", 32'(water_out_o), 32'(a.water));
        if (surface_out_o !== a.surface)
          report("surface_out", 32'(surface_out_o), 32'(a.surface));
        if (status_o !== a.status) report("status", 32'(status_o), 32'(a.status));
      end
      out_stall = bursty ? 0 : $urandom_range(0, 4);
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      idle_cycles = 0;
      in_taken = 1'b1;
      answers_q.push_back(apply_word({command_i, cell_index_i, ground_height_i,
                                      water_level_i}));
    end
    if (idle_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_word(input logic [CMD_W-1:0] cmd, input int idx,
                           input logic [GROUND_W-1:0] g, input logic [WATER_W-1:0] wl);
    cell_word_t w;
    w.cmd = cmd;
    w.idx = CIDX_W'(idx);
    w.ground = g;
    w.water = wl;
    pending_q.push_back(w);
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_q.size() > 0 || in_valid_i || answers_q.size() > 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (a == REG_THRESHOLD) threshold_m = d[THR_W-1:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // wet cells stay in a few small patches so steps finish quickly
  function automatic int wet_cell();
    int r, c;
    case ($urandom_range(0, 2))
      0: begin r = $urandom_range(0, 3); c = $urandom_range(0, 15); end
      1: begin r = $urandom_range(Side - 4, Side - 1); c = $urandom_range(Side - 16, Side - 1); end
      default: begin r = Side / 2; c = $urandom_range(60, 70); end
    endcase
    return r * Side + c;
  endfunction

  function automatic logic [WATER_W-1:0] rand_water();
    case ($urandom_range(0, 3))
      0: return WATER_MAX - WATER_W'($urandom_range(0, 3));
      1: return WATER_W'($urandom_range(0, 1 << 20));
      default: return WATER_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [THR_W-1:0] thr [4];
    int pick;
    thr[0] = '0;
    thr[1] = 16'hFFFF;
    thr[2] = THR_W'($urandom());
    thr[3] = THR_RESET;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed corners and out-of-grid cases
    push_word(CMD_LOAD, 0, 8'hFF, WATER_MAX);
    push_word(CMD_LOAD, Cells - 1, 8'h00, '0);
    push_word(CMD_LOAD, Side - 1, 8'h80, 28'h5555555);
    push_word(CMD_READ, 0, '0, '0);
    push_word(CMD_READ, Cells - 1, 8'hFF, WATER_MAX);
    push_word(CMD_READ, Side - 1, '0, '0);
    push_word(CMD_LOAD, Cells, 8'hAA, 28'hAAAAAAA);
    push_word(CMD_READ, Cells, '0, '0);
    push_word(CMD_LOAD, 32767, 8'hFF, WATER_MAX);
    push_word(CMD_READ, 32767, 8'hFF, WATER_MAX);
    push_word(CMD_NOP, 12345, 8'h5A, 28'h1234567);
    push_word(CMD_NOP, 32767, 8'hFF, WATER_MAX);
    drain();
    cfg_write(REG_THRESHOLD, 32'hFFFF_0000);
    cfg_write(3'd4, 32'h0000_1234);

    // every cell must hold data before a step
    for (int i = 0; i < Cells; i++) push_word(CMD_LOAD, i, GROUND_W'($urandom()), '0);
    push_word(CMD_LOAD, 0, 8'hFF, WATER_MAX);
    push_word(CMD_LOAD, 1, 8'h00, 28'h0FF_0000);
    push_word(CMD_LOAD, Side, 8'h10, 28'h0000100);
    push_word(CMD_LOAD, Cells - 1, 8'hFF, 28'h0800000);
    push_word(CMD_STEP, 32767, 8'hFF, WATER_MAX);
    for (int i = 0; i < 4; i++) push_word(CMD_READ, i, '0, '0);
    push_word(CMD_READ, Side, '0, '0);
    push_word(CMD_READ, Cells - 2, '0, '0);
    push_word(CMD_READ, Cells - 1, '0, '0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(REG_THRESHOLD, PDATA_W'(thr[ph]));
      for (int i = 0; i < 415; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) push_word(CMD_LOAD, wet_cell(), GROUND_W'($urandom()), rand_water());
        else if (pick < 4)
          push_word(CMD_LOAD, $urandom_range(0, Cells - 1), GROUND_W'($urandom()), '0);
        else if (pick < 5) push_word(CMD_READ, wet_cell(), GROUND_W'($urandom()), rand_water());
        else if (pick < 7)
          push_word(CMD_READ, $urandom_range(0, Cells - 1), GROUND_W'($urandom()), rand_water());
        else if (pick < 8)
          push_word($urandom_range(0, 1) ? CMD_LOAD : CMD_READ, $urandom_range(Cells, 32767),
                    GROUND_W'($urandom()), WATER_W'($urandom()));
        else
          push_word(CMD_NOP, $urandom_range(0, 32767), GROUND_W'($urandom()),
                    WATER_W'($urandom()));
      end
      push_word(CMD_STEP, $urandom_range(0, 32767), GROUND_W'($urandom()), WATER_W'($urandom()));
      for (int i = 0; i < 40; i++) push_word(CMD_READ, wet_cell(), '0, '0);
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/hwfs_pkg.sv
hw/rtl/heightfield_water_flow_step.sv
bench/testbench.sv
